// ===== hdl/hcsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_pkg
// Types, constants and quarter-round helpers shared by the HChaCha20 subkey
// pipeline.
// ----------------------------------------------------------------------------
package hcsd_pkg;

   typedef logic [31:0] word_type;
   typedef logic [15:0][31:0] state_type;

   // Nonce half-words, low bytes in the low bits.
   typedef struct packed {
      logic [63:0] nonce_bytes_8_to_15;
      logic [63:0] nonce_bytes_0_to_7;
   } req_type;

   typedef struct packed {
      logic [63:0] subkey_bytes_24_to_31;
      logic [63:0] subkey_bytes_16_to_23;
      logic [63:0] subkey_bytes_8_to_15;
      logic [63:0] subkey_bytes_0_to_7;
   } rsp_type;

   // One quarter-round lane
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } lane_type;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int KEY_REGS        = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_BYTES_0_TO_7   = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_BYTES_8_TO_15  = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_BYTES_16_TO_23 = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_BYTES_24_TO_31 = 8'd3;

   localparam word_type SIGMA_0 = 32'h61707865;
   localparam word_type SIGMA_1 = 32'h3320646E;
   localparam word_type SIGMA_2 = 32'h79622D32;
   localparam word_type SIGMA_3 = 32'h6B206574;

   localparam int DOUBLE_ROUNDS = 10;
   // Each round is split into two half quarter-rounds, one per stage.
   localparam int NUM_STAGES    = DOUBLE_ROUNDS * 4;

   localparam int ROT_FIRST_D  = 16;
   localparam int ROT_FIRST_B  = 12;
   localparam int ROT_SECOND_D = 8;
   localparam int ROT_SECOND_B = 7;

   function automatic word_type rotl(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic lane_type qr_first(input lane_type x);
      lane_type r;
      r   = x;
      r.a = r.a + r.b;
      r.d = rotl(r.d ^ r.a, ROT_FIRST_D);
      r.c = r.c + r.d;
      r.b = rotl(r.b ^ r.c, ROT_FIRST_B);
      return r;
   endfunction

   function automatic lane_type qr_second(input lane_type x);
      lane_type r;
      r   = x;
      r.a = r.a + r.b;
      r.d = rotl(r.d ^ r.a, ROT_SECOND_D);
      r.c = r.c + r.d;
      r.b = rotl(r.b ^ r.c, ROT_SECOND_B);
      return r;
   endfunction

endpackage

// ===== hdl/hcsd_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_stage
// One pipeline stage: half of a column or diagonal round on all four lanes,
// with the valid bit registered alongside the state.
// ----------------------------------------------------------------------------
module hcsd_stage #(
   parameter int DIAGONAL    = 0,
   parameter int SECOND_HALF = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  logic               in_valid,
   input  hcsd_pkg::state_type in_state,
   output logic               out_valid,
   output hcsd_pkg::state_type out_state
);

   logic                valid_ff;
   hcsd_pkg::state_type state_ff;
   hcsd_pkg::state_type state_in;

   always_comb begin
      hcsd_pkg::lane_type lane_in;
      hcsd_pkg::lane_type lane_out;
      logic [3:0] ia;
      logic [3:0] ib;
      logic [3:0] ic;
      logic [3:0] id;
      state_in = in_state;
      for (int q = 0; q < 4; q++) begin
         // diagonal lanes rotate rows 1..3 by one, two and three words
         ia = 4'(q);
         ib = 4'(4 + ((q + DIAGONAL) & 3));
         ic = 4'(8 + ((q + 2 * DIAGONAL) & 3));
         id = 4'(12 + ((q + 3 * DIAGONAL) & 3));
         lane_in.a = in_state[ia];
         lane_in.b = in_state[ib];
         lane_in.c = in_state[ic];
         lane_in.d = in_state[id];
         lane_out = (SECOND_HALF != 0) ? hcsd_pkg::qr_second(lane_in)
                                       : hcsd_pkg::qr_first(lane_in);
         state_in[ia] = lane_out.a;
         state_in[ib] = lane_out.b;
         state_in[ic] = lane_out.c;
         state_in[id] = lane_out.d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

// ===== hdl/hchacha20_subkey_derive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hchacha20_subkey_derive
// HChaCha20 subkey engine: 256-bit key from CSRs, 128-bit nonce per request.
// ----------------------------------------------------------------------------
// Takes one request per cycle while req_stall is low and returns its subkey
// in request order. Each request passes through the round pipeline:
// 40 stages, each doing half of one quarter-round (two dependent
// 32-bit adds) on all four lanes. The whole pipeline holds while a result
// waits on rsp_stall. Key registers must be written while no request is in
// flight; writes to indexes above three are dropped.
module hchacha20_subkey_derive (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_enable,
   input  logic [hcsd_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [hcsd_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  hcsd_pkg::req_type                        req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output hcsd_pkg::rsp_type                        rsp_payload
);

   logic [hcsd_pkg::CSR_DATA_WIDTH-1:0] key_ff [hcsd_pkg::KEY_REGS];
   logic                enable;
   hcsd_pkg::state_type init_state;
   logic                valid_chain [hcsd_pkg::NUM_STAGES + 1];
   hcsd_pkg::state_type state_chain [hcsd_pkg::NUM_STAGES + 1];
   hcsd_pkg::state_type final_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < hcsd_pkg::KEY_REGS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_write_enable) begin
         case (csr_index)
            hcsd_pkg::CSR_KEY_BYTES_0_TO_7:   key_ff[0] <= csr_write_data;
            hcsd_pkg::CSR_KEY_BYTES_8_TO_15:  key_ff[1] <= csr_write_data;
            hcsd_pkg::CSR_KEY_BYTES_16_TO_23: key_ff[2] <= csr_write_data;
            hcsd_pkg::CSR_KEY_BYTES_24_TO_31: key_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Pipeline moves unless a finished result is being held.
   assign enable    = !(valid_chain[hcsd_pkg::NUM_STAGES] && rsp_stall);
   assign req_stall = !enable;

   always_comb begin
      init_state[0]  = hcsd_pkg::SIGMA_0;
      init_state[1]  = hcsd_pkg::SIGMA_1;
      init_state[2]  = hcsd_pkg::SIGMA_2;
      init_state[3]  = hcsd_pkg::SIGMA_3;
      for (int k = 0; k < hcsd_pkg::KEY_REGS; k++) begin
         init_state[4 + 2 * k]     = key_ff[k][31:0];
         init_state[4 + 2 * k + 1] = key_ff[k][63:32];
      end
      init_state[12] = req_payload.nonce_bytes_0_to_7[31:0];
      init_state[13] = req_payload.nonce_bytes_0_to_7[63:32];
      init_state[14] = req_payload.nonce_bytes_8_to_15[31:0];
      init_state[15] = req_payload.nonce_bytes_8_to_15[63:32];
   end

   assign valid_chain[0] = req_valid;
   assign state_chain[0] = init_state;

   for (genvar s = 0; s < hcsd_pkg::NUM_STAGES; s++) begin : g_stage
      hcsd_stage #(
         .DIAGONAL    ((s / 2) % 2),
         .SECOND_HALF (s % 2)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (valid_chain[s]),
         .in_state  (state_chain[s]),
         .out_valid (valid_chain[s + 1]),
         .out_state (state_chain[s + 1])
      );
   end

   assign final_state = state_chain[hcsd_pkg::NUM_STAGES];
   assign rsp_valid   = valid_chain[hcsd_pkg::NUM_STAGES];

   assign rsp_payload.subkey_bytes_0_to_7   = {final_state[1],  final_state[0]};
   assign rsp_payload.subkey_bytes_8_to_15  = {final_state[3],  final_state[2]};
   assign rsp_payload.subkey_bytes_16_to_23 = {final_state[13], final_state[12]};
   assign rsp_payload.subkey_bytes_24_to_31 = {final_state[15], final_state[14]};

endmodule

// ===== hdl/hcsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcsd_checker
// Port-level checks for the HChaCha20 subkey engine, bound to the top level.
// ----------------------------------------------------------------------------
module hcsd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hcsd_pkg::rsp_type rsp_payload
);

   // A held result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Requests are stalled exactly when a result is held.
   a_stall_match: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow result stall");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A new result only appears after the pipeline moved.
   a_rise_on_move: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_stall))
      else $error("result appeared while pipeline held");

endmodule

bind hchacha20_subkey_derive hcsd_checker u_hcsd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HChaCha20 subkey engine.
// ----------------------------------------------------------------------------
// Nonce requests come from a queue that the stimulus block fills phase by
// phase. Each phase but the first loads a key through the CSR port while the
// pipeline is empty. An independent HChaCha20 implementation predicts each
// subkey when its request is accepted, and each response is checked field by
// field against the oldest prediction. The sender runs in random bursts and
// the receiver stalls on its own schedule. One phase holds the receiver off
// long enough to back the pipeline up into req_stall.
module tb;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PATTERN,
      STALL_HEAVY
   } stall_mode_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_REQUESTS = 164;

   localparam logic [hcsd_pkg::CSR_INDEX_WIDTH-1:0] CSR_INDEX_LAST = '1;
   localparam logic [hcsd_pkg::CSR_INDEX_WIDTH-1:0] KEY_INDEX [hcsd_pkg::KEY_REGS] = '{
      hcsd_pkg::CSR_KEY_BYTES_0_TO_7, hcsd_pkg::CSR_KEY_BYTES_8_TO_15,
      hcsd_pkg::CSR_KEY_BYTES_16_TO_23, hcsd_pkg::CSR_KEY_BYTES_24_TO_31
   };

   logic                                 clock;
   logic                                 reset            = 1'b1;
   logic                                 csr_write_enable = 1'b0;
   logic [hcsd_pkg::CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [hcsd_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;
   logic                                 req_valid        = 1'b0;
   logic                                 req_stall;
   hcsd_pkg::req_type                    req_payload      = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall        = 1'b0;
   hcsd_pkg::rsp_type                    rsp_payload;

   hcsd_pkg::req_type nonce_queue[$];
   hcsd_pkg::rsp_type subkey_expected[$];
   logic [63:0]       key_copy [hcsd_pkg::KEY_REGS];
   int                mismatch_count = 0;
   int                idle_cycles    = 0;

   // sender and receiver behavior, set by the stimulus block
   bit             sender_gaps   = 1'b0;
   stall_mode_type stall_mode    = STALL_NONE;
   int             hold_requests = 0;

   int             burst_left  = 0;
   int             gap_left    = 0;
   int             hold_served = 0;
   int             hold_left   = 0;
   int             stall_phase = 0;

   hchacha20_subkey_derive u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Subkey predictor
   // ---------------------------------------------------------------------
   function automatic hcsd_pkg::word_type rol32(hcsd_pkg::word_type v, int n);
      logic [63:0] twice;
      twice = {v, v} << n;
      return twice[63:32];
   endfunction

   function automatic hcsd_pkg::state_type mix_words(hcsd_pkg::state_type s,
                                                     int a, int b, int c, int d);
      s[a] = s[a] + s[b];  s[d] = rol32(s[d] ^ s[a], hcsd_pkg::ROT_FIRST_D);
      s[c] = s[c] + s[d];  s[b] = rol32(s[b] ^ s[c], hcsd_pkg::ROT_FIRST_B);
      s[a] = s[a] + s[b];  s[d] = rol32(s[d] ^ s[a], hcsd_pkg::ROT_SECOND_D);
      s[c] = s[c] + s[d];  s[b] = rol32(s[b] ^ s[c], hcsd_pkg::ROT_SECOND_B);
      return s;
   endfunction

   function automatic hcsd_pkg::rsp_type derive_subkey(hcsd_pkg::req_type nonce);
      hcsd_pkg::state_type s;
      hcsd_pkg::rsp_type   subkey;
      s[0] = hcsd_pkg::SIGMA_0;
      s[1] = hcsd_pkg::SIGMA_1;
      s[2] = hcsd_pkg::SIGMA_2;
      s[3] = hcsd_pkg::SIGMA_3;
      for (int i = 0; i < 8; i++) begin
         s[4 + i] = key_copy[i >> 1][32 * (i & 1) +: 32];
      end
      s[12] = nonce.nonce_bytes_0_to_7[31:0];
      s[13] = nonce.nonce_bytes_0_to_7[63:32];
      s[14] = nonce.nonce_bytes_8_to_15[31:0];
      s[15] = nonce.nonce_bytes_8_to_15[63:32];
      for (int r = 0; r < hcsd_pkg::DOUBLE_ROUNDS; r++) begin
         s = mix_words(s, 0, 4, 8, 12);
         s = mix_words(s, 1, 5, 9, 13);
         s = mix_words(s, 2, 6, 10, 14);
         s = mix_words(s, 3, 7, 11, 15);
         s = mix_words(s, 0, 5, 10, 15);
         s = mix_words(s, 1, 6, 11, 12);
         s = mix_words(s, 2, 7, 8, 13);
         s = mix_words(s, 3, 4, 9, 14);
      end
      // no feed-forward add in HChaCha20
      subkey.subkey_bytes_0_to_7   = {s[1], s[0]};
      subkey.subkey_bytes_8_to_15  = {s[3], s[2]};
      subkey.subkey_bytes_16_to_23 = {s[13], s[12]};
      subkey.subkey_bytes_24_to_31 = {s[15], s[14]};
      return subkey;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [63:0] random_half();
      int          kind;
      logic [63:0] one_bit;
      kind    = $urandom_range(0, 9);
      one_bit = 64'd1 << $urandom_range(0, 63);
      case (kind)
         0: return '0;
         1: return '1;
         2: return one_bit;
         3: return ~one_bit;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic hcsd_pkg::req_type random_nonce();
      hcsd_pkg::req_type n;
      n.nonce_bytes_0_to_7  = random_half();
      n.nonce_bytes_8_to_15 = random_half();
      return n;
   endfunction

   function automatic hcsd_pkg::req_type make_nonce(logic [63:0] low, logic [63:0] high);
      hcsd_pkg::req_type n;
      n.nonce_bytes_0_to_7  = low;
      n.nonce_bytes_8_to_15 = high;
      return n;
   endfunction

   // Enable stays high across back-to-back writes; close_csr drops it.
   task automatic put_csr(logic [hcsd_pkg::CSR_INDEX_WIDTH-1:0] index, logic [63:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
   endtask

   task automatic close_csr();
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic put_ignored_csr();
      put_csr(hcsd_pkg::CSR_INDEX_WIDTH'($urandom_range(
                 hcsd_pkg::CSR_KEY_BYTES_24_TO_31 + 1, CSR_INDEX_LAST)),
              {$urandom, $urandom});
   endtask

   task automatic drain();
      while (nonce_queue.size() != 0 || req_valid || subkey_expected.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: random bursts, optionally separated by random gaps
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         burst_left  = 0;
         gap_left    = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (nonce_queue.size() != 0) begin
            req_valid   <= 1'b1;
            req_payload <= nonce_queue.pop_front();
            if (burst_left > 0) burst_left = burst_left - 1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = sender_gaps ? $urandom_range(1, 8) : 0;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall pattern, with a long hold-off on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         hold_served = hold_requests;
         hold_left   = 0;
         stall_phase = 0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_phase = (stall_phase + 1) % 7;
         case (stall_mode)
            STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 35);
            STALL_PATTERN: rsp_stall <= (stall_phase >= 4);
            STALL_HEAVY:   rsp_stall <= ($urandom_range(0, 99) < 80);
            default:       rsp_stall <= 1'b0;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: key shadow, prediction on accept, response check
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      hcsd_pkg::rsp_type expected;
      if (reset) begin
         for (int i = 0; i < hcsd_pkg::KEY_REGS; i++) key_copy[i] = '0;
      end else begin
         if (csr_write_enable && csr_index <= hcsd_pkg::CSR_KEY_BYTES_24_TO_31)
            key_copy[csr_index[1:0]] = csr_write_data;
         if (req_valid && !req_stall)
            subkey_expected.push_back(derive_subkey(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (subkey_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected response %h", rsp_payload);
            end else begin
               expected = subkey_expected.pop_front();
               for (int f = 0; f < 4; f++) begin
                  if (rsp_payload[64 * f +: 64] !== expected[64 * f +: 64]) begin
                     mismatch_count++;
                     if (mismatch_count <= MAX_REPORTS)
                        $display("subkey bytes %0d..%0d: expected %h actual %h",
                                 8 * f, 8 * f + 7, expected[64 * f +: 64],
                                 rsp_payload[64 * f +: 64]);
                  end
               end
            end
         end
      end
   end

   // Watchdog on cycles with no activity on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // key never written: all-zero key from reset
      nonce_queue.push_back(make_nonce('0, '0));
      nonce_queue.push_back(make_nonce('1, '1));
      nonce_queue.push_back(make_nonce(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
      nonce_queue.push_back(make_nonce(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000));
      drain();

      // all-ones key; out-of-range writes must not disturb it
      for (int i = 0; i < hcsd_pkg::KEY_REGS; i++) put_csr(KEY_INDEX[i], '1);
      put_ignored_csr();
      put_csr(CSR_INDEX_LAST, {$urandom, $urandom});
      close_csr();
      nonce_queue.push_back(make_nonce('0, '0));
      nonce_queue.push_back(make_nonce('1, '1));
      nonce_queue.push_back(make_nonce(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
      nonce_queue.push_back(make_nonce(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF));
      drain();

      // published XChaCha20 draft vector: key bytes 00..1f
      put_csr(hcsd_pkg::CSR_KEY_BYTES_0_TO_7,   64'h0706_0504_0302_0100);
      put_csr(hcsd_pkg::CSR_KEY_BYTES_8_TO_15,  64'h0F0E_0D0C_0B0A_0908);
      put_csr(hcsd_pkg::CSR_KEY_BYTES_16_TO_23, 64'h1716_1514_1312_1110);
      put_csr(hcsd_pkg::CSR_KEY_BYTES_24_TO_31, 64'h1F1E_1D1C_1B1A_1918);
      close_csr();
      nonce_queue.push_back(make_nonce(64'h4A00_0000_0900_0000, 64'h2759_4131_0000_0000));
      nonce_queue.push_back(make_nonce('1, '0));
      nonce_queue.push_back(make_nonce('0, '1));
      drain();

      // random phases, each with its own key and flow-control mix
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         for (int i = 0; i < hcsd_pkg::KEY_REGS; i++) begin
            if (phase == 0)
               put_csr(KEY_INDEX[i], '0);
            else if (phase == 1)
               put_csr(KEY_INDEX[i], '1);
            else
               put_csr(KEY_INDEX[i], random_half());
         end
         if ($urandom_range(0, 1)) put_ignored_csr();
         close_csr();
         stall_mode  = stall_mode_type'(phase % 4);
         sender_gaps = (phase % 3) != 0;
         if (phase == 5) hold_requests++;
         repeat (PHASE_REQUESTS) nonce_queue.push_back(random_nonce());
         drain();
      end

      repeat (2 * hcsd_pkg::NUM_STAGES) @(posedge clock);
      if (mismatch_count == 0 && subkey_expected.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
